@@ rtl/cigsp_pkg.sv @@
`timescale 1ns / 1ps
package cigsp_pkg;

  localparam int unsigned RUN_W  = 28;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 280;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // bytes at or below this value are never decoded as operations
  localparam logic [7:0] LETTER_FLOOR = 8'd60;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_X  = 8'h58;

  localparam logic [CODE_W-1:0] OP_M  = 4'd0;
  localparam logic [CODE_W-1:0] OP_I  = 4'd1;
  localparam logic [CODE_W-1:0] OP_D  = 4'd2;
  localparam logic [CODE_W-1:0] OP_N  = 4'd3;
  localparam logic [CODE_W-1:0] OP_S  = 4'd4;
  localparam logic [CODE_W-1:0] OP_H  = 4'd5;
  localparam logic [CODE_W-1:0] OP_P  = 4'd6;
  localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
  localparam logic [CODE_W-1:0] OP_X  = 4'd8;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
    logic              tgt;
    logic              qry;
    logic              mat;
    logic              aln;
  } op_dec_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_len;
    logic [SUM_W-1:0] tpos;
    logic [SUM_W-1:0] qpos;
    logic [SUM_W-1:0] mcnt;
    logic [SUM_W-1:0] acnt;
    logic             err;
  } parse_st_t;

  typedef struct packed {
    logic [CODE_W-1:0] op_code;
    logic [RUN_W-1:0]  op_len;
    logic [SUM_W-1:0]  target_offset;
    logic [SUM_W-1:0]  query_offset;
    logic [RUN_W-1:0]  target_span;
    logic [RUN_W-1:0]  query_span;
    logic [SUM_W-1:0]  match_total;
    logic [SUM_W-1:0]  aligned_total;
    logic [SUM_W-1:0]  target_total;
    logic [SUM_W-1:0]  query_total;
    logic              bad_op;
    logic              string_end;
  } event_t;

  function automatic op_dec_t op_decode(input logic [7:0] ch);
    op_dec_t d;
    d = '0;
    d.ok = 1'b1;
    unique case (ch)
      CH_M:  begin d.code = OP_M;  d.tgt = 1'b1; d.qry = 1'b1; d.mat = 1'b1; d.aln = 1'b1; end
      CH_I:  begin d.code = OP_I;  d.qry = 1'b1; d.aln = 1'b1; end
      CH_D:  begin d.code = OP_D;  d.tgt = 1'b1; d.aln = 1'b1; end
      CH_N:  begin d.code = OP_N;  d.tgt = 1'b1; d.aln = 1'b1; end
      CH_S:  begin d.code = OP_S;  d.qry = 1'b1; end
      CH_H:  d.code = OP_H;
      CH_P:  d.code = OP_P;
      CH_EQ: begin d.code = OP_EQ; d.tgt = 1'b1; d.qry = 1'b1; d.mat = 1'b1; d.aln = 1'b1; end
      CH_X:  begin d.code = OP_X;  d.tgt = 1'b1; d.qry = 1'b1; d.aln = 1'b1; end
      default: d = '0;
    endcase
    if (ch <= LETTER_FLOOR) begin
      d = '0;
    end
    return d;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [RUN_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W+1-RUN_W){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/cigar_string_parser_unit.sv @@
`timescale 1ns / 1ps
// CIGAR string parser: takes one character per transfer on the in_ stream,
// in_tlast marking the last character of a string. Digits build up a run
// length; each operation letter gives one event on the out_ stream with the
// code, length, offsets before the operation, spans and running totals.
// A bad byte gives one event with out_tuser high and the rest of that
// string is dropped up to its last character. Digits give no event.
// A character is captured in the input register, decoded and added in one
// combinational pass, and its event is loaded into the output register,
// which drives out_tvalid; a stall on out_tready can hold it in between.
// Throughput: one character per cycle while out_tready stays high; the limit
// is the saturating add and multiply-by-ten on the running state.
// Reset (rst_n low, synchronous) empties both registers and clears the run
// length, positions, totals and error flag. While out_tready is low the
// output register holds its event and the input register still takes one
// more character; after that in_tready drops until the event moves on.
module cigar_string_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cigsp_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] char_byte
  input  logic                                 in_tlast,   // final_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] op_code, [31:4] op_len, [63:32] target_offset, [95:64] query_offset,
  // [123:96] target_span, [151:124] query_span, [183:152] match_total,
  // [215:184] aligned_total, [247:216] target_total, [279:248] query_total
  output logic [cigsp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,  // string_end
  output logic                                 out_tuser   // bad_op
);
  import cigsp_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;
  logic       adv;

  parse_st_t  st_r;
  parse_st_t  st_nxt;
  event_t     evt;
  event_t     evt_r;
  logic       emit;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // step fires when the input register holds a byte and the result slot is free
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
    end
  end

  cigsp_step u_step (
    .st         (st_r),
    .char_byte  (in_char_r),
    .final_byte (in_last_r),
    .st_nxt     (st_nxt),
    .evt        (evt),
    .emit       (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (adv) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      evt_r <= evt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {evt_r.query_total, evt_r.target_total, evt_r.aligned_total,
                       evt_r.match_total, evt_r.query_span, evt_r.target_span,
                       evt_r.query_offset, evt_r.target_offset, evt_r.op_len,
                       evt_r.op_code};
  assign out_tlast  = evt_r.string_end;
  assign out_tuser  = evt_r.bad_op;

  // a bad byte carries no operation and no length
  a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && evt_r.bad_op |->
      evt_r.op_len == '0 && evt_r.target_span == '0 && evt_r.query_span == '0)
    else $error("bad_op event with nonzero length");

  // target total is offset plus span unless the sum saturated
  a_tgt_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && evt_r.target_total != SUM_MAX |->
      evt_r.target_total == evt_r.target_offset + {{(SUM_W-RUN_W){1'b0}}, evt_r.target_span})
    else $error("target total does not match offset plus span");

  // spans are either the whole length or nothing
  a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (evt_r.target_span == '0 || evt_r.target_span == evt_r.op_len) &&
      (evt_r.query_span == '0 || evt_r.query_span == evt_r.op_len))
    else $error("span differs from op length");

  // the last byte of a string leaves all parse state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> st_r == '0)
    else $error("state not cleared after final byte");

  // an errored record produces no further events
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r.err |=> !out_valid_r || $stable(evt_r))
    else $error("event produced inside errored record");

endmodule

@@ rtl/cigsp_step.sv @@
`timescale 1ns / 1ps
module cigsp_step (
  input  cigsp_pkg::parse_st_t st,
  input  logic [7:0]           char_byte,
  input  logic                 final_byte,
  output cigsp_pkg::parse_st_t st_nxt,
  output cigsp_pkg::event_t    evt,
  output logic                 emit
);
  import cigsp_pkg::*;

  op_dec_t          dec;
  logic             is_digit;
  logic [SUM_W-1:0] run_wide;
  logic [RUN_W-1:0] run_acc;
  logic [RUN_W-1:0] len;
  logic [RUN_W-1:0] tspan;
  logic [RUN_W-1:0] qspan;
  logic [SUM_W-1:0] tpos_upd;
  logic [SUM_W-1:0] qpos_upd;
  logic [SUM_W-1:0] mcnt_upd;
  logic [SUM_W-1:0] acnt_upd;

  assign dec      = op_decode(char_byte);
  assign is_digit = (char_byte >= CH_0) && (char_byte <= CH_9);

  // run * 10 + digit as two shifts and two adds; fits in 32 bits before saturation
  assign run_wide = ({{(SUM_W-RUN_W){1'b0}}, st.run_len} << 3)
                  + ({{(SUM_W-RUN_W){1'b0}}, st.run_len} << 1)
                  + {{(SUM_W-4){1'b0}}, char_byte[3:0] - CH_0[3:0]};
  assign run_acc  = (run_wide > {{(SUM_W-RUN_W){1'b0}}, RUN_MAX}) ? RUN_MAX
                                                                 : run_wide[RUN_W-1:0];

  assign len   = dec.ok ? st.run_len : '0;
  assign tspan = dec.tgt ? len : '0;
  assign qspan = dec.qry ? len : '0;

  assign tpos_upd = sat_add(st.tpos, tspan);
  assign qpos_upd = sat_add(st.qpos, qspan);
  assign mcnt_upd = dec.mat ? sat_add(st.mcnt, len) : st.mcnt;
  assign acnt_upd = dec.aln ? sat_add(st.acnt, len) : st.acnt;

  always_comb begin
    evt.op_code       = dec.code;
    evt.op_len        = len;
    evt.target_offset = st.tpos;
    evt.query_offset  = st.qpos;
    evt.target_span   = tspan;
    evt.query_span    = qspan;
    evt.match_total   = mcnt_upd;
    evt.aligned_total = acnt_upd;
    evt.target_total  = tpos_upd;
    evt.query_total   = qpos_upd;
    evt.bad_op        = !dec.ok;
    evt.string_end    = final_byte;
  end

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    if (st.err) begin
      // rest of a broken record is dropped
    end else if (is_digit) begin
      st_nxt.run_len = run_acc;
    end else begin
      emit = 1'b1;
      if (dec.ok) begin
        st_nxt.tpos    = tpos_upd;
        st_nxt.qpos    = qpos_upd;
        st_nxt.mcnt    = mcnt_upd;
        st_nxt.acnt    = acnt_upd;
        st_nxt.run_len = '0;
      end else begin
        st_nxt.err = 1'b1;
      end
    end
    if (final_byte) begin
      st_nxt = '0;
    end
  end

endmodule
